>>> sv/msaa_triangle_raster_zbuffer_top_assert.svh
// Assertion macros for the MSAA triangle rasterizer top level.
`ifndef MSAA_TRIANGLE_RASTER_ZBUFFER_TOP_ASSERT_SVH
`define MSAA_TRIANGLE_RASTER_ZBUFFER_TOP_ASSERT_SVH

// Clocked check, off while reset is high.
`define MTRZ_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) expr) else $error(msg);

// Clocked check that also runs through reset.
`define MTRZ_ASSERT_ALWAYS(lbl, clk, expr, msg) \
   lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

>>> sv/mtrz_pkg.sv
// Shared types, constants and helpers for the MSAA triangle rasterizer.
package mtrz_pkg;

   localparam int SCREEN_WIDTH_DEF  = 256;
   localparam int SCREEN_HEIGHT_DEF = 256;

   localparam int COORD_W = 14;
   localparam int DEPTH_W = 16;
   localparam int COLOR_W = 24;
   localparam int CNT_W   = 17;
   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 16;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int NUM_W   = 50;
   localparam int DIVS_W  = 35;
   localparam int DIVD_W  = DIVS_W + DEPTH_W;

   localparam logic [FUNC_W-1:0] FUNC_DRAW      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLR_COLOR = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLR_DEPTH = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLR_BOTH  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

   localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DEPTH_W-1:0] quotient;
   } div_rsp_type;

   // subsample offset in 1/16 pixel units
   function automatic logic [3:0] samp_off_x(input logic [1:0] s);
      return s[0] ? 4'd12 : 4'd4;
   endfunction

   function automatic logic [3:0] samp_off_y(input logic [1:0] s);
      return s[1] ? 4'd12 : 4'd4;
   endfunction

   function automatic logic signed [COORD_W-1:0] min3(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // channel * coverage / 4, floor
   function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [2:0] n);
      logic [10:0] p;
      p = 11'(ch) * 11'(n);
      return p[9:2];
   endfunction

endpackage

>>> sv/mtrz_ram.sv
// Generic single write port RAM with registered read.
module mtrz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

>>> sv/mtrz_mul.sv
// Shared signed multiplier with registered product.
module mtrz_mul
   import mtrz_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> sv/mtrz_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
module mtrz_div
   import mtrz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIVS_W-1:0]      rem_ff, rem_in;
   logic [DEPTH_W-1:0]     q_ff, q_in;
   logic [DIVS_W-1:0]      dvs_ff;
   logic [4:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIVS_W:0]        trial;
   logic [DIVS_W:0]        diff;

   assign trial = {rem_ff, q_ff[DEPTH_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.dividend[DIVD_W-1:DEPTH_W];
         q_in    = req.dividend[DEPTH_W-1:0];
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIVS_W-1:0];
            q_in   = {q_ff[DEPTH_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVS_W-1:0];
            q_in   = {q_ff[DEPTH_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (req.start) begin
         dvs_ff <= req.divisor;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

>>> sv/msaa_triangle_raster_zbuffer_top.sv
// Top level: MSAA triangle rasterizer with color and depth stores.
//
// Request channel (req_*): one item per request, taken when req_valid is
// high and req_stall low. func selects draw, clear color, clear depth,
// clear both or read pixel. The block takes one request at a time and holds
// req_stall high while it works on it.
// Response channel (rsp_*): exactly one response per request, held in an
// output register while rsp_stall is high; the next request may be taken
// while a response waits, and its own result waits for the register.
// Config: csr_we writes csr_wdata to msaa_enable (reset 1); write only
// while idle.
// A draw has one setup step, then per pixel of the clipped box the edge
// tests for each sample on the shared multiplier, plus depth interpolation
// (3 multiplies, then the divider) per covered sample, plus a step to close
// the pixel and then address, depth read and write on a covered pixel.
// Reset: a clearing pass writes every store entry, one entry a cycle, with
// req_stall high, then goes idle with no response; config writes are still
// taken.
`include "msaa_triangle_raster_zbuffer_top_assert.svh"

module msaa_triangle_raster_zbuffer_top
   import mtrz_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [COORD_W-1:0] req_vert0_x,
   input  logic signed [COORD_W-1:0] req_vert0_y,
   input  logic signed [COORD_W-1:0] req_vert1_x,
   input  logic signed [COORD_W-1:0] req_vert1_y,
   input  logic signed [COORD_W-1:0] req_vert2_x,
   input  logic signed [COORD_W-1:0] req_vert2_y,
   input  logic [DEPTH_W-1:0]        req_vert0_depth,
   input  logic [DEPTH_W-1:0]        req_vert1_depth,
   input  logic [DEPTH_W-1:0]        req_vert2_depth,
   input  logic [COLOR_W-1:0]        req_tri_color,
   input  logic [INDEX_W-1:0]        req_read_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COLOR_W-1:0]        rsp_read_color,
   output logic [DEPTH_W-1:0]        rsp_read_depth,
   output logic [CNT_W-1:0]          rsp_pixels_written,
   input  logic                      csr_we,
   input  logic                      csr_wdata
);

   localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW = $clog2(STORE_SIZE);
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam logic signed [11:0] XMAX = 12'(SCREEN_WIDTH - 1);
   localparam logic signed [11:0] YMAX = 12'(SCREEN_HEIGHT - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
   localparam logic [INDEX_W:0] STORE_LIM = (STORE_SIZE > 65535) ? '1 : (INDEX_W+1)'(STORE_SIZE);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SETUP = 4'd2;
   localparam logic [3:0] S_EDGE  = 4'd3;
   localparam logic [3:0] S_TEST  = 4'd4;
   localparam logic [3:0] S_NUM   = 4'd5;
   localparam logic [3:0] S_DIVGO = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_PIXE  = 4'd8;
   localparam logic [3:0] S_ADDR  = 4'd9;
   localparam logic [3:0] S_ADDR2 = 4'd10;
   localparam logic [3:0] S_CMP   = 4'd11;
   localparam logic [3:0] S_RD    = 4'd12;
   localparam logic [3:0] S_RD2   = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [3:0] state_ff, state_in;

   // item registers
   logic signed [COORD_W-1:0] vx_ff [3];
   logic signed [COORD_W-1:0] vy_ff [3];
   logic [DEPTH_W-1:0]        vd_ff [3];
   logic [COLOR_W-1:0]        col_ff;
   logic [INDEX_W-1:0]        rd_idx_ff;
   logic                      msaa_ff;

   // walk state
   logic [XW-1:0] x_ff, x0_ff, x1_ff;
   logic [YW-1:0] y_ff, y1_ff;
   logic [1:0]    s_ff;
   logic [2:0]    st_ff;
   logic [2:0]    count_ff;
   logic [DEPTH_W-1:0] best_ff;
   logic signed [MUL_A_W-1:0] e_ff [3];
   logic [NUM_W-1:0] num_ff;
   logic [AW-1:0]    idx_ff;

   // clear sweep; boot_ff marks the pass after reset, which gives no response
   logic [AW-1:0] clr_cnt_ff;
   logic          clr_c_ff, clr_d_ff;
   logic          boot_ff;

   // results
   logic [COLOR_W-1:0] res_color_ff;
   logic [DEPTH_W-1:0] res_depth_ff;
   logic [CNT_W-1:0]   res_cnt_ff;
   logic               rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;

   logic req_acc;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // ---------------- shared multiplier ----------------
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   mtrz_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   // sample point in 1/16 pixel units
   logic [3:0] offx, offy;
   logic signed [16:0] px, py;
   assign offx = msaa_ff ? samp_off_x(s_ff) : 4'd8;
   assign offy = msaa_ff ? samp_off_y(s_ff) : 4'd8;
   assign px   = $signed(17'({x_ff, offx}));
   assign py   = $signed(17'({y_ff, offy}));

   logic [1:0] ej;
   logic signed [COORD_W-1:0] ax, ay, bx, by;
   logic signed [14:0] dxab, dyab;
   logic signed [16:0] dpx, dpy;

   assign ej = st_ff[2:1];
   always_comb begin
      case (ej)
         2'd0: begin
            ax = vx_ff[0]; ay = vy_ff[0]; bx = vx_ff[1]; by = vy_ff[1];
         end
         2'd1: begin
            ax = vx_ff[1]; ay = vy_ff[1]; bx = vx_ff[2]; by = vy_ff[2];
         end
         default: begin
            ax = vx_ff[2]; ay = vy_ff[2]; bx = vx_ff[0]; by = vy_ff[0];
         end
      endcase
   end

   assign dxab = 15'(bx) - 15'(ax);
   assign dyab = 15'(by) - 15'(ay);
   assign dpx  = px - 17'(ax);
   assign dpy  = py - 17'(ay);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EDGE: begin
            if (st_ff[0]) begin
               mul_a = MUL_A_W'(dyab);
               mul_b = MUL_B_W'(dpx);
            end else begin
               mul_a = MUL_A_W'(dxab);
               mul_b = MUL_B_W'(dpy);
            end
         end
         S_NUM: begin
            case (st_ff[1:0])
               2'd0: begin
                  mul_a = e_ff[1];
                  mul_b = $signed({2'b00, vd_ff[0]});
               end
               2'd1: begin
                  mul_a = e_ff[2];
                  mul_b = $signed({2'b00, vd_ff[1]});
               end
               default: begin
                  mul_a = e_ff[0];
                  mul_b = $signed({2'b00, vd_ff[2]});
               end
            endcase
         end
         S_ADDR: begin
            mul_a = $signed(MUL_A_W'(YW'(SCREEN_HEIGHT - 1) - y_ff));
            mul_b = MUL_B_W'(SCREEN_WIDTH);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------- divider ----------------
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic [DIVS_W-1:0] sum;

   assign sum = DIVS_W'(e_ff[0][MUL_A_W-2:0]) + DIVS_W'(e_ff[1][MUL_A_W-2:0])
              + DIVS_W'(e_ff[2][MUL_A_W-2:0]);
   assign div_req.start    = (state_ff == S_DIVGO);
   assign div_req.divisor  = sum;
   assign div_req.dividend = DIVD_W'(num_ff) + DIVD_W'(sum >> 1);

   mtrz_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------- stores ----------------
   logic              c_we, d_we;
   logic [AW-1:0]     waddr, raddr;
   logic [COLOR_W-1:0] c_wdata, c_rdata;
   logic [DEPTH_W-1:0] d_wdata, d_rdata;
   logic [AW-1:0]     idx_calc;
   logic              pix_win;

   assign idx_calc = AW'(prod) + AW'(x_ff);
   assign pix_win  = (d_rdata > best_ff);

   always_comb begin
      c_we    = 1'b0;
      d_we    = 1'b0;
      waddr   = idx_ff;
      c_wdata = {scale_ch(col_ff[23:16], count_ff), scale_ch(col_ff[15:8], count_ff),
                 scale_ch(col_ff[7:0], count_ff)};
      d_wdata = best_ff;
      raddr   = AW'(rd_idx_ff);
      if (state_ff == S_CLR) begin
         c_we    = clr_c_ff;
         d_we    = clr_d_ff;
         waddr   = clr_cnt_ff;
         c_wdata = '0;
         d_wdata = DEPTH_FAR;
      end else if (state_ff == S_CMP) begin
         c_we = pix_win;
         d_we = pix_win;
      end
      if (state_ff == S_ADDR2) begin
         raddr = idx_calc;
      end
   end

   mtrz_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_SIZE)) u_color (
      .clock    (clock),
      .we       (c_we),
      .waddr    (waddr),
      .wdata    (c_wdata),
      .raddr    (raddr),
      .rdata_ff (c_rdata)
   );

   mtrz_ram #(.WIDTH(DEPTH_W), .DEPTH(STORE_SIZE)) u_depth (
      .clock    (clock),
      .we       (d_we),
      .waddr    (waddr),
      .wdata    (d_wdata),
      .raddr    (raddr),
      .rdata_ff (d_rdata)
   );

   // ---------------- bounding box ----------------
   logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
   logic signed [14:0] cxs, cys;
   logic signed [11:0] fx, fy, cx, cy, bx0, bx1, by0, by1;
   logic box_empty;

   assign minx = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
   assign maxx = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
   assign miny = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
   assign maxy = max3(vy_ff[0], vy_ff[1], vy_ff[2]);
   assign cxs  = 15'(maxx) + 15'sd15;
   assign cys  = 15'(maxy) + 15'sd15;
   assign fx   = 12'(minx >>> 4);
   assign fy   = 12'(miny >>> 4);
   assign cx   = 12'(cxs >>> 4);
   assign cy   = 12'(cys >>> 4);
   assign bx0  = (fx < 0) ? 12'sd0 : fx;
   assign by0  = (fy < 0) ? 12'sd0 : fy;
   assign bx1  = (cx > XMAX) ? XMAX : cx;
   assign by1  = (cy > YMAX) ? YMAX : cy;
   assign box_empty = (bx1 < bx0) || (by1 < by0);

   // ---------------- sequencer ----------------
   logic [2:0] prev_op;
   logic [1:0] pj;
   logic       last_samp, last_pix;
   logic signed [MUL_A_W-1:0] prod_e;

   assign prev_op   = st_ff - 3'd1;
   assign pj        = prev_op[2:1];
   assign prod_e    = MUL_A_W'(prod);
   assign last_samp = !msaa_ff || (s_ff == 2'd3);
   assign last_pix  = (x_ff == x1_ff) && (y_ff == y1_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = boot_ff ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_func)
                  FUNC_DRAW: state_in = S_SETUP;
                  FUNC_CLR_COLOR, FUNC_CLR_DEPTH, FUNC_CLR_BOTH: state_in = S_CLR;
                  FUNC_READ:
                     state_in = ({1'b0, req_read_index} < STORE_LIM) ? S_RD : S_DONE;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SETUP: state_in = box_empty ? S_DONE : S_EDGE;
         S_EDGE:  state_in = (st_ff == 3'd6) ? S_TEST : S_EDGE;
         S_TEST: begin
            if (e_ff[0] > 0 && e_ff[1] > 0 && e_ff[2] > 0) begin
               state_in = S_NUM;
            end else begin
               state_in = last_samp ? S_PIXE : S_EDGE;
            end
         end
         S_NUM:   state_in = (st_ff == 3'd3) ? S_DIVGO : S_NUM;
         S_DIVGO: state_in = S_DIV;
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = last_samp ? S_PIXE : S_EDGE;
            end
         end
         S_PIXE: begin
            if (count_ff != 3'd0) begin
               state_in = S_ADDR;
            end else begin
               state_in = last_pix ? S_DONE : S_EDGE;
            end
         end
         S_ADDR:  state_in = S_ADDR2;
         S_ADDR2: state_in = S_CMP;
         S_CMP:   state_in = last_pix ? S_DONE : S_EDGE;
         S_RD:    state_in = S_RD2;
         S_RD2:   state_in = S_DONE;
         S_DONE:  state_in = (!rsp_valid_ff || !rsp_stall) ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         clr_c_ff     <= 1'b1;
         clr_d_ff     <= 1'b1;
         boot_ff      <= 1'b1;
         msaa_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         res_color_ff <= '0;
         res_depth_ff <= '0;
         res_cnt_ff   <= '0;
         st_ff        <= '0;
         s_ff         <= '0;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            msaa_ff <= csr_wdata;
         end
         // a finished request refills the output register as it drains
         if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
            end
            S_IDLE: begin
               boot_ff <= 1'b0;
               if (req_acc) begin
                  res_color_ff <= '0;
                  res_depth_ff <= '0;
                  res_cnt_ff   <= '0;
                  clr_cnt_ff   <= '0;
                  clr_c_ff     <= req_func[0];
                  clr_d_ff     <= req_func[1];
               end
            end
            S_SETUP: begin
               x_ff     <= XW'(bx0);
               x0_ff    <= XW'(bx0);
               x1_ff    <= XW'(bx1);
               y_ff     <= YW'(by0);
               y1_ff    <= YW'(by1);
               st_ff    <= '0;
               s_ff     <= '0;
               count_ff <= '0;
            end
            S_EDGE: begin
               st_ff <= st_ff + 3'd1;
               if (st_ff != 3'd0) begin
                  if (prev_op[0]) begin
                     e_ff[pj] <= e_ff[pj] - prod_e;
                  end else begin
                     e_ff[pj] <= prod_e;
                  end
               end
            end
            S_TEST: begin
               st_ff <= '0;
               if (!(e_ff[0] > 0 && e_ff[1] > 0 && e_ff[2] > 0) && !last_samp) begin
                  s_ff <= s_ff + 2'd1;
               end
            end
            S_NUM: begin
               st_ff <= st_ff + 3'd1;
               if (st_ff == 3'd1) begin
                  num_ff <= prod[NUM_W-1:0];
               end else if (st_ff != 3'd0) begin
                  num_ff <= num_ff + prod[NUM_W-1:0];
               end
            end
            S_DIVGO: begin
               st_ff <= '0;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  if (count_ff == 3'd0 || div_rsp.quotient < best_ff) begin
                     best_ff <= div_rsp.quotient;
                  end
                  count_ff <= count_ff + 3'd1;
                  if (!last_samp) begin
                     s_ff <= s_ff + 2'd1;
                  end
               end
            end
            S_PIXE: begin
               if (!msaa_ff && count_ff != 3'd0) begin
                  count_ff <= 3'd4;
               end
               if (count_ff == 3'd0 && !last_pix) begin
                  s_ff <= '0;
                  if (x_ff == x1_ff) begin
                     x_ff <= x0_ff;
                     y_ff <= y_ff + YW'(1);
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end
            end
            S_ADDR2: begin
               idx_ff <= idx_calc;
            end
            S_CMP: begin
               if (pix_win && res_cnt_ff != '1) begin
                  res_cnt_ff <= res_cnt_ff + CNT_W'(1);
               end
               count_ff <= '0;
               s_ff     <= '0;
               if (!last_pix) begin
                  if (x_ff == x1_ff) begin
                     x_ff <= x0_ff;
                     y_ff <= y_ff + YW'(1);
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end
            end
            S_RD2: begin
               res_color_ff <= c_rdata;
               res_depth_ff <= d_rdata;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         vx_ff[0]  <= req_vert0_x;
         vy_ff[0]  <= req_vert0_y;
         vx_ff[1]  <= req_vert1_x;
         vy_ff[1]  <= req_vert1_y;
         vx_ff[2]  <= req_vert2_x;
         vy_ff[2]  <= req_vert2_y;
         vd_ff[0]  <= req_vert0_depth;
         vd_ff[1]  <= req_vert1_depth;
         vd_ff[2]  <= req_vert2_depth;
         col_ff    <= req_tri_color;
         rd_idx_ff <= req_read_index;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_color_ff <= res_color_ff;
         rsp_depth_ff <= res_depth_ff;
         rsp_cnt_ff   <= res_cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_color     = rsp_color_ff;
   assign rsp_read_depth     = rsp_depth_ff;
   assign rsp_pixels_written = rsp_cnt_ff;

   // ---------------- checks ----------------
   `MTRZ_ASSERT(a_cmp_has_cov, clock, reset, (state_ff == S_CMP) |-> (count_ff != 3'd0), "depth compare without coverage")
   `MTRZ_ASSERT(a_div_in_draw, clock, reset, div_rsp.done |-> (state_ff == S_DIV), "divider result outside wait state")
   `MTRZ_ASSERT_ALWAYS(a_rst_stall, clock, $past(reset) |-> req_stall, "request taken during reset clear")

endmodule
